[rtl/websocket_frame_deframer_defines.svh]
// Assertion macros shared by the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsfd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsfd: next-cycle check failed");

`endif

[rtl/wsfd_pkg.sv]
// Types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsfd_pkg;

    localparam int LEN_W  = 19;
    localparam int BYTE_W = 8;
    localparam int KEY_W  = 32;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Limit register reset value
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 19'd262144;

    // Byte 1 length codes that announce an extended length
    localparam logic [6:0] L7_EXT16 = 7'd126;
    localparam logic [6:0] L7_EXT64 = 7'd127;

    // Header sizes in bytes and extended length byte counts
    localparam logic [3:0] HDR_SHORT = 4'd2;
    localparam logic [3:0] HDR_EXT16 = 4'd4;
    localparam logic [3:0] HDR_EXT64 = 4'd10;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef struct packed {
        logic [1:0]        kind;
        logic              final_fragment;
        logic [3:0]        frame_opcode;
        logic              was_masked;
        logic [LEN_W-1:0]  payload_length;
        logic [LEN_W-1:0]  total_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
    } t_result;

endpackage

[rtl/wsfd_parser.sv]
// Frame header parser and payload unmasker: one stream byte per accepted transfer.
`timescale 1ns / 1ps
module wsfd_parser
    import wsfd_pkg::*;
#(
    parameter int MAX_PAYLOAD_BOUND = 262144
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [LEN_W-1:0]  i_max_payload,
    output logic              o_emit,
    output t_result           o_res
);

    localparam int BOUND_W = $clog2(MAX_PAYLOAD_BOUND + 1);
    localparam int CMP_W   = (BOUND_W > LEN_W) ? BOUND_W : LEN_W;
    localparam logic [CMP_W-1:0] BOUND_V = CMP_W'(MAX_PAYLOAD_BOUND);

    // Parser phases
    localparam logic [2:0] PH_BYTE0   = 3'd0;
    localparam logic [2:0] PH_BYTE1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    logic [2:0]       r_phase,    n_phase;
    logic             r_fin,      n_fin;
    logic [3:0]       r_opcode,   n_opcode;
    logic             r_mask,     n_mask;
    logic [LEN_W-1:0] r_len,      n_len;
    logic             r_len_big,  n_len_big;   // length bits above the field are set
    logic [3:0]       r_cnt,      n_cnt;
    logic [KEY_W-1:0] r_key,      n_key;
    logic [LEN_W-1:0] r_pos,      n_pos;
    logic [3:0]       r_hdr_size, n_hdr_size;
    logic             r_ext_long, n_ext_long;

    logic [LEN_W-1:0]  limit;
    logic              chk;
    logic              hdr;
    logic              over;
    logic              empty;
    logic [BYTE_W-1:0] key_byte;
    logic [3:0]        ext_needed;

    // Effective limit: the smaller of the register and the bound
    always_comb begin
        if (CMP_W'(i_max_payload) > BOUND_V) begin
            limit = BOUND_V[LEN_W-1:0];
        end else begin
            limit = i_max_payload;
        end
    end

    assign ext_needed = r_ext_long ? EXT64_BYTES : EXT16_BYTES;

    // Mask key byte for the current payload position, first key byte in the top bits
    always_comb begin
        case (r_pos[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // Next state and result for the byte at the input
    always_comb begin
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_opcode   = r_opcode;
        n_mask     = r_mask;
        n_len      = r_len;
        n_len_big  = r_len_big;
        n_cnt      = r_cnt;
        n_key      = r_key;
        n_pos      = r_pos;
        n_hdr_size = r_hdr_size;
        n_ext_long = r_ext_long;
        chk        = 1'b0;
        hdr        = 1'b0;
        over       = 1'b0;
        empty      = 1'b0;
        o_emit     = 1'b0;
        o_res      = '0;

        case (r_phase)
            PH_BYTE0: begin
                n_fin     = i_byte[7];
                n_opcode  = i_byte[3:0];
                n_mask    = 1'b0;
                n_len     = '0;
                n_len_big = 1'b0;
                n_cnt     = '0;
                n_pos     = '0;
                n_key     = '0;
                n_phase   = PH_BYTE1;
            end
            PH_BYTE1: begin
                n_mask    = i_byte[7];
                n_cnt     = '0;
                n_len     = '0;
                n_len_big = 1'b0;
                if (i_byte[6:0] == L7_EXT16) begin
                    n_ext_long = 1'b0;
                    n_hdr_size = HDR_EXT16;
                    n_phase    = PH_EXTLEN;
                end else if (i_byte[6:0] == L7_EXT64) begin
                    n_ext_long = 1'b1;
                    n_hdr_size = HDR_EXT64;
                    n_phase    = PH_EXTLEN;
                end else begin
                    n_ext_long = 1'b0;
                    n_hdr_size = HDR_SHORT;
                    n_len      = LEN_W'(i_byte[6:0]);
                    chk        = 1'b1;
                end
            end
            PH_EXTLEN: begin
                // big-endian shift in; bits leaving the low field go into the sticky flag
                n_len     = {r_len[LEN_W-BYTE_W-1:0], i_byte};
                n_len_big = r_len_big | (r_len[LEN_W-1:LEN_W-BYTE_W] != '0);
                n_cnt     = r_cnt + 4'd1;
                chk       = (n_cnt >= ext_needed);
            end
            PH_MASK: begin
                n_key = {r_key[KEY_W-BYTE_W-1:0], i_byte};
                n_cnt = r_cnt + 4'd1;
                hdr   = (n_cnt >= KEY_BYTES);
            end
            PH_PAYLOAD: begin
                n_pos                = r_pos + LEN_W'(1);
                o_emit               = 1'b1;
                o_res.kind           = KIND_PAYLOAD;
                o_res.final_fragment = r_fin;
                o_res.frame_opcode   = r_opcode;
                o_res.was_masked     = r_mask;
                o_res.payload_length = r_len;
                o_res.total_length   = LEN_W'(r_hdr_size) + (r_mask ? LEN_W'(4) : '0) + r_len;
                o_res.payload_byte   = i_byte ^ (r_mask ? key_byte : '0);
                o_res.last           = (n_pos >= r_len);
                if (o_res.last) begin
                    n_phase = PH_BYTE0;
                end
            end
            PH_ERROR: begin
                // discard everything until reset
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // Length known: limit check, then mask key or header
        if (chk) begin
            over = n_len_big | (n_len > limit);
            if (over) begin
                o_emit               = 1'b1;
                o_res.kind           = KIND_ERROR;
                o_res.final_fragment = n_fin;
                o_res.frame_opcode   = n_opcode;
                o_res.was_masked     = n_mask;
                o_res.payload_length = '1;
                n_phase              = PH_ERROR;
            end else if (n_mask) begin
                n_cnt   = '0;
                n_key   = '0;
                n_phase = PH_MASK;
            end else begin
                hdr = 1'b1;
            end
        end

        // Header complete
        if (hdr) begin
            empty                = (n_len == '0);
            n_pos                = '0;
            n_phase              = empty ? PH_BYTE0 : PH_PAYLOAD;
            o_emit               = 1'b1;
            o_res.kind           = KIND_HEADER;
            o_res.final_fragment = n_fin;
            o_res.frame_opcode   = n_opcode;
            o_res.was_masked     = n_mask;
            o_res.payload_length = n_len;
            o_res.total_length   = LEN_W'(n_hdr_size) + (n_mask ? LEN_W'(4) : '0) + n_len;
            o_res.last           = empty;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_BYTE0;
            r_fin      <= 1'b0;
            r_opcode   <= '0;
            r_mask     <= 1'b0;
            r_len      <= '0;
            r_len_big  <= 1'b0;
            r_cnt      <= '0;
            r_key      <= '0;
            r_pos      <= '0;
            r_hdr_size <= HDR_SHORT;
            r_ext_long <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_fin      <= n_fin;
            r_opcode   <= n_opcode;
            r_mask     <= n_mask;
            r_len      <= n_len;
            r_len_big  <= n_len_big;
            r_cnt      <= n_cnt;
            r_key      <= n_key;
            r_pos      <= n_pos;
            r_hdr_size <= n_hdr_size;
            r_ext_long <= n_ext_long;
        end
    end

endmodule

[rtl/wsfd_obuf.sv]
// Result register with a skid entry so the input keeps flowing under output stall until the skid entry holds a result.
`timescale 1ns / 1ps
module wsfd_obuf
    import wsfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out
);

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Output slot refills from the skid entry first, then from a new result
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = i_res_valid;
                n_skid       = i_res;
            end else begin
                n_out_valid = i_res_valid;
                n_out       = i_res;
            end
        end else if (i_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[rtl/websocket_frame_deframer.sv]
// A completed result is registered in the output register or its skid entry.
// Throughput: one stream byte per cycle unless stalled, a single parser pass per byte.
// Input stall rises only when both the result register and its skid entry hold results.
// Reset (synchronous, active low) returns the parser to the first header byte,
// clears the result and skid valids and restores max_payload to 262144.
`timescale 1ns / 1ps
module websocket_frame_deframer
    import wsfd_pkg::*;
#(
    parameter int MAX_PAYLOAD_BOUND = 262144
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data,
    // stream input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_stream_byte,
    // results
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_kind,
    output logic              o_final_fragment,
    output logic [3:0]        o_frame_opcode,
    output logic              o_was_masked,
    output logic [LEN_W-1:0]  o_payload_length,
    output logic [LEN_W-1:0]  o_total_length,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_last
);

    logic [LEN_W-1:0] r_max_payload;
    logic             full;
    logic             accept;
    logic             emit;
    t_result          res;
    t_result          out;

    // Limit register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_payload <= i_cfg_data;
        end
    end

    // Input transfer
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    wsfd_parser #(
        .MAX_PAYLOAD_BOUND(MAX_PAYLOAD_BOUND)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte        (i_stream_byte),
        .i_max_payload (r_max_payload),
        .o_emit        (emit),
        .o_res         (res)
    );

    wsfd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (accept && emit),
        .i_res       (res),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (out)
    );

    assign o_kind           = out.kind;
    assign o_final_fragment = out.final_fragment;
    assign o_frame_opcode   = out.frame_opcode;
    assign o_was_masked     = out.was_masked;
    assign o_payload_length = out.payload_length;
    assign o_total_length   = out.total_length;
    assign o_payload_byte   = out.payload_byte;
    assign o_last           = out.last;

endmodule

[rtl/wsfd_checker.sv]
// Port-level checker for the deframer, bound to the top level.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"
module wsfd_checker
    import wsfd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [1:0]        o_kind,
    input logic [LEN_W-1:0]  o_payload_length,
    input logic [LEN_W-1:0]  o_total_length,
    input logic [BYTE_W-1:0] o_payload_byte,
    input logic              o_last
);

    // A stalled result holds until its transfer
    `WSFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_payload_byte) && $stable(o_payload_length) && $stable(o_last))

    // Error results carry the fixed error pattern
    `WSFD_ASSERT_IMPL(a_err_fields, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_ERROR), (o_payload_length == '1) && (o_total_length == '0) && !o_last && (o_payload_byte == '0))

    // Header marks last exactly for an empty frame
    `WSFD_ASSERT_IMPL(a_hdr_last, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_HEADER), (o_last == (o_payload_length == '0)) && (o_payload_byte == '0))

    // Payload bytes only belong to frames with a nonzero length
    `WSFD_ASSERT_IMPL(a_pay_len, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_PAYLOAD), o_payload_length != '0)

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (.*);

[test/testbench.sv]
// Self-checking testbench for the WebSocket frame deframer: byte stream in, predicted results out.
`timescale 1ns / 1ps
module testbench;
    import wsfd_pkg::*;

    localparam int unsigned PAYLOAD_BOUND = 262144;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [2:0] {
        ST_HDR0, ST_HDR1, ST_EXTLEN, ST_KEY, ST_DATA, ST_HALTED
    } t_dec_state;

    typedef enum logic [1:0] {ENC_SHORT, ENC_EXT16, ENC_EXT64} t_len_enc;

    typedef struct {
        logic [7:0] data;
        bit         quiet;
    } t_stream_item;

    // Clock, reset and block inputs
    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic [LEN_W-1:0]  cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic [BYTE_W-1:0] stream_byte = '0;
    logic              out_stall   = 1'b0;

    // Block outputs
    logic              cfg_ready;
    logic              in_stall;
    logic              out_valid;
    logic [1:0]        out_kind;
    logic              out_fin;
    logic [3:0]        out_opcode;
    logic              out_masked;
    logic [LEN_W-1:0]  out_plen;
    logic [LEN_W-1:0]  out_total;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    // Stimulus and expected results
    t_stream_item stream_q[$];
    t_result      expected_results[$];
    bit           cur_quiet = 1'b0;
    int           gap_left;
    int           stall_left;
    int           stuck_cycles;

    // Statistics
    int n_mismatch     = 0;
    int n_bytes_queued = 0;
    int n_bytes_in     = 0;
    int n_frames       = 0;
    int n_limit_writes = 0;
    int n_headers      = 0;
    int n_payload      = 0;
    int n_errors       = 0;

    // Decoder state kept alongside the block
    t_dec_state       dec_state     = ST_HDR0;
    logic             dec_fin       = 1'b0;
    logic [3:0]       dec_opcode    = '0;
    logic             dec_masked    = 1'b0;
    logic [63:0]      dec_len       = '0;
    logic [3:0]       dec_count     = '0;
    logic [3:0]       dec_ext_bytes = '0;
    logic [3:0]       dec_hdr_size  = HDR_SHORT;
    logic [31:0]      dec_key       = '0;
    logic [LEN_W-1:0] dec_pos       = '0;
    logic [LEN_W-1:0] limit_reg     = MAX_PAYLOAD_RST;

    websocket_frame_deframer #(
        .MAX_PAYLOAD_BOUND(PAYLOAD_BOUND)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_stream_byte    (stream_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_kind           (out_kind),
        .o_final_fragment (out_fin),
        .o_frame_opcode   (out_opcode),
        .o_was_masked     (out_masked),
        .o_payload_length (out_plen),
        .o_total_length   (out_total),
        .o_payload_byte   (out_byte),
        .o_last           (out_last)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Frame decoder prediction
    // ---------------------------------------------------------------

    // Limit in force: register value capped by the build-time bound
    function automatic int unsigned effective_limit();
        return (limit_reg > PAYLOAD_BOUND) ? PAYLOAD_BOUND : limit_reg;
    endfunction

    function automatic logic [63:0] frame_total();
        return 64'(dec_hdr_size) + (dec_masked ? 64'd4 : 64'd0) + dec_len;
    endfunction

    function automatic t_result make_result(logic [1:0] k, logic [63:0] plen,
                                            logic [63:0] total, logic [7:0] data,
                                            logic lst);
        t_result r;
        r.kind           = k;
        r.final_fragment = dec_fin;
        r.frame_opcode   = dec_opcode;
        r.was_masked     = dec_masked;
        r.payload_length = plen[LEN_W-1:0];
        r.total_length   = total[LEN_W-1:0];
        r.payload_byte   = data;
        r.last           = lst;
        return r;
    endfunction

    // Header complete: report it, then payload or back to the next frame
    function automatic bit finish_header(output t_result r);
        r = make_result(KIND_HEADER, dec_len, frame_total(), 8'h00, dec_len == 0);
        dec_pos   = '0;
        dec_state = (dec_len == 0) ? ST_HDR0 : ST_DATA;
        return 1'b1;
    endfunction

    // Length fully known: oversize check comes before any mask key byte
    function automatic bit length_ready(output t_result r);
        r = '0;
        if (dec_len > 64'(effective_limit())) begin
            r = make_result(KIND_ERROR, {64{1'b1}}, 64'd0, 8'h00, 1'b0);
            dec_state = ST_HALTED;
            return 1'b1;
        end
        if (dec_masked) begin
            dec_count = '0;
            dec_key   = '0;
            dec_state = ST_KEY;
            return 1'b0;
        end
        return finish_header(r);
    endfunction

    // One stream byte in, at most one result out
    function automatic bit decode_byte(input logic [7:0] b, output t_result r);
        logic [6:0] l7;
        logic [7:0] k;
        logic       lst;
        r = '0;
        case (dec_state)
            ST_HDR0: begin
                dec_fin    = b[7];
                dec_opcode = b[3:0];
                dec_masked = 1'b0;
                dec_len    = '0;
                dec_count  = '0;
                dec_pos    = '0;
                dec_key    = '0;
                dec_state  = ST_HDR1;
                return 1'b0;
            end
            ST_HDR1: begin
                l7         = b[6:0];
                dec_masked = b[7];
                dec_count  = '0;
                dec_len    = '0;
                if (l7 == L7_EXT16) begin
                    dec_ext_bytes = EXT16_BYTES;
                    dec_hdr_size  = HDR_EXT16;
                    dec_state     = ST_EXTLEN;
                    return 1'b0;
                end
                if (l7 == L7_EXT64) begin
                    dec_ext_bytes = EXT64_BYTES;
                    dec_hdr_size  = HDR_EXT64;
                    dec_state     = ST_EXTLEN;
                    return 1'b0;
                end
                dec_ext_bytes = '0;
                dec_hdr_size  = HDR_SHORT;
                dec_len       = 64'(l7);
                return length_ready(r);
            end
            ST_EXTLEN: begin
                // extended length arrives big-endian
                dec_len   = {dec_len[55:0], b};
                dec_count = dec_count + 4'd1;
                if (dec_count < dec_ext_bytes) return 1'b0;
                return length_ready(r);
            end
            ST_KEY: begin
                dec_key   = {dec_key[23:0], b};
                dec_count = dec_count + 4'd1;
                if (dec_count < KEY_BYTES) return 1'b0;
                return finish_header(r);
            end
            ST_DATA: begin
                // key byte 0 is the first one received
                k = dec_masked ? dec_key[31 - 8 * dec_pos[1:0] -: 8] : 8'h00;
                dec_pos = dec_pos + LEN_W'(1);
                lst = (64'(dec_pos) >= dec_len);
                r = make_result(KIND_PAYLOAD, dec_len, frame_total(), b ^ k, lst);
                if (lst) dec_state = ST_HDR0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------

    // Idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void push_byte(logic [7:0] b, bit quiet);
        stream_q.push_back(t_stream_item'{b, quiet});
        n_bytes_queued++;
    endfunction

    // Header bytes; reserved bits of byte 0 are random since the block ignores them
    function automatic void add_header(logic fin, logic [3:0] opcode, logic masked,
                                       t_len_enc enc, logic [63:0] len, bit quiet);
        push_byte({fin, 3'($urandom_range(0, 7)), opcode}, quiet);
        case (enc)
            ENC_SHORT: begin
                push_byte({masked, len[6:0]}, quiet);
            end
            ENC_EXT16: begin
                push_byte({masked, L7_EXT16}, quiet);
                push_byte(len[15:8], quiet);
                push_byte(len[7:0], quiet);
            end
            default: begin
                push_byte({masked, L7_EXT64}, quiet);
                for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8], quiet);
            end
        endcase
        if (masked) begin
            repeat (4) push_byte(8'($urandom_range(0, 255)), quiet);
        end
        n_frames++;
    endfunction

    function automatic void add_frame(logic fin, logic [3:0] opcode, logic masked,
                                      t_len_enc enc, int unsigned len, bit quiet);
        add_header(fin, opcode, masked, enc, 64'(len), quiet);
        repeat (len) push_byte(8'($urandom_range(0, 255)), quiet);
    endfunction

    function automatic int unsigned clamp_len(int unsigned cap, int unsigned hi);
        return (cap < hi) ? cap : hi;
    endfunction

    // Well-formed frame within the current limit, mostly short payloads
    function automatic void add_random_frame();
        int unsigned cap;
        int unsigned len;
        int          sel;
        t_len_enc    enc;
        cap = effective_limit();
        sel = $urandom_range(0, 99);
        if (cap == 0 || sel < 8) len = 0;
        else if (sel < 70) len = $urandom_range(1, clamp_len(cap, 20));
        else if (sel < 92) len = $urandom_range(1, clamp_len(cap, 130));
        else len = $urandom_range(1, clamp_len(cap, 400));
        sel = $urandom_range(0, 9);
        if (len <= 125) enc = (sel < 6) ? ENC_SHORT : (sel < 9) ? ENC_EXT16 : ENC_EXT64;
        else enc = (sel < 7) ? ENC_EXT16 : ENC_EXT64;
        add_frame(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), enc, len, $urandom_range(0, 99) < 15);
    endfunction

    // Wait until stimulus is sent and every result is back, then let the block settle
    task automatic wait_idle();
        while (stream_q.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_payload(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
        n_limit_writes++;
    endtask

    // ---------------------------------------------------------------
    // Stream driver: one byte per transfer, random gaps between bytes
    // ---------------------------------------------------------------
    always @(posedge clk) begin : driver
        t_stream_item item;
        t_result      res;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            cur_quiet <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall) begin
                n_bytes_in++;
                if (decode_byte(stream_byte, res)) expected_results.push_back(res);
                gap_left = cur_quiet ? 0 : pick_idle();
            end
            if (in_valid && in_stall) begin
                // stalled: hold the byte
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (stream_q.size() != 0) begin
                item = stream_q.pop_front();
                in_valid    <= 1'b1;
                stream_byte <= item.data;
                cur_quiet   <= item.quiet;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and checker
    // ---------------------------------------------------------------
    function automatic void check_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $display("unexpected result: kind=%0d plen=%0d byte=%h last=%0d",
                         got.kind, got.payload_length, got.payload_byte, got.last);
            return;
        end
        want = expected_results.pop_front();
        case (want.kind)
            KIND_HEADER:  n_headers++;
            KIND_PAYLOAD: n_payload++;
            default:      n_errors++;
        endcase
        if (got.kind !== want.kind || got.final_fragment !== want.final_fragment ||
            got.frame_opcode !== want.frame_opcode || got.was_masked !== want.was_masked ||
            got.payload_length !== want.payload_length ||
            got.total_length !== want.total_length ||
            got.payload_byte !== want.payload_byte || got.last !== want.last) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
                $display("mismatch: expected kind=%0d fin=%0d op=%h mask=%0d plen=%0d",
                         want.kind, want.final_fragment, want.frame_opcode,
                         want.was_masked, want.payload_length);
                $display("          total=%0d byte=%h last=%0d", want.total_length,
                         want.payload_byte, want.last);
                $display("          actual kind=%0d fin=%0d op=%h mask=%0d plen=%0d",
                         got.kind, got.final_fragment, got.frame_opcode,
                         got.was_masked, got.payload_length);
                $display("          total=%0d byte=%h last=%0d", got.total_length,
                         got.payload_byte, got.last);
            end
        end
    endfunction

    always @(posedge clk) begin : monitor
        t_result got;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                got.kind           = out_kind;
                got.final_fragment = out_fin;
                got.frame_opcode   = out_opcode;
                got.was_masked     = out_masked;
                got.payload_length = out_plen;
                got.total_length   = out_total;
                got.payload_byte   = out_byte;
                got.last           = out_last;
                check_result(got);
            end
            // back-pressure: occasional stalls of random length
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!cur_quiet && $urandom_range(0, 3) == 0) begin
                stall_left = pick_idle();
                out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long
    always @(posedge clk) begin : watchdog
        if (!rst_n) begin
            stuck_cycles = 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                     (cfg_valid && cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles, %0d results outstanding",
                         stuck_cycles, expected_results.size());
                $display("websocket_frame_deframer test failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin : sequence_main
        int          target;
        int unsigned edge_limit;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset limit
        add_frame(1'b1, 4'h1, 1'b0, ENC_SHORT, 0, 1'b0);   // empty, unmasked
        add_frame(1'b1, 4'h9, 1'b1, ENC_SHORT, 0, 1'b0);   // empty, masked
        add_frame(1'b0, 4'h2, 1'b0, ENC_SHORT, 1, 1'b0);
        add_frame(1'b1, 4'h0, 1'b1, ENC_SHORT, 6, 1'b0);   // key wraps past byte 3
        add_frame(1'b0, 4'hF, 1'b1, ENC_EXT16, 0, 1'b0);   // empty via 16-bit length
        add_frame(1'b1, 4'h8, 1'b0, ENC_EXT64, 0, 1'b0);   // empty via 64-bit length
        add_frame(1'b1, 4'hA, 1'b1, ENC_EXT64, 5, 1'b0);
        add_frame(1'b0, 4'h2, 1'b1, ENC_SHORT, 125, 1'b0); // largest 7-bit length
        wait_idle();

        // Register above the bound: the bound governs
        set_max_payload({LEN_W{1'b1}});
        target = n_bytes_queued + 420;
        while (n_bytes_queued < target) add_random_frame();
        wait_idle();

        // Zero limit: only empty frames pass
        set_max_payload('0);
        add_frame(1'b1, 4'h9, 1'b1, ENC_EXT64, 0, 1'b0);
        repeat (8) add_random_frame();
        wait_idle();

        set_max_payload(19'd200);
        target = n_bytes_queued + 300;
        while (n_bytes_queued < target) add_random_frame();
        wait_idle();

        set_max_payload(MAX_PAYLOAD_RST);
        target = n_bytes_queued + 300;
        while (n_bytes_queued < target) add_random_frame();
        wait_idle();

        // Random limit: a frame right at it, then one past it, then ignored traffic
        edge_limit = $urandom_range(126, 600);
        set_max_payload(LEN_W'(edge_limit));
        add_frame(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), ENC_EXT16, edge_limit, 1'b0);
        if ($urandom_range(0, 1))
            add_header(1'b1, 4'h2, 1'($urandom_range(0, 1)), ENC_EXT16,
                       64'(edge_limit + 1), 1'b0);
        else
            add_header(1'b0, 4'h1, 1'($urandom_range(0, 1)), ENC_EXT64,
                       {1'b1, 31'($urandom), 32'($urandom)}, 1'b0);
        repeat (40) push_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_idle();
        repeat (20) @(posedge clk);

        $display("sent %0d stream bytes in %0d frames under %0d limit settings",
                 n_bytes_in, n_frames, n_limit_writes + 1);
        $display("checked %0d headers, %0d payload bytes, %0d length errors; %0d mismatches",
                 n_headers, n_payload, n_errors, n_mismatch);
        if (n_mismatch == 0) begin
            $display("websocket_frame_deframer test passed");
        end else begin
            $display("websocket_frame_deframer test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_parser.sv
rtl/wsfd_obuf.sv
rtl/websocket_frame_deframer.sv
rtl/wsfd_checker.sv
test/testbench.sv
